>>> hdl/salc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// salc_pkg
// shared constants and types for the set-associative cache with write buffer
// ---------------------------------------------------------------------------
package salc_pkg;
    localparam int WAYS = 4;
    localparam int SETS = 64;
    localparam int LINE_BYTES = 64;
    localparam int BUFFER_DEPTH = 8;
    localparam int ADDR_BITS = 32;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int TAG_W = ADDR_BITS - OFF_W - ((SETS > 1) ? $clog2(SETS) : 0);
    localparam int BUF_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int QDEPTH = 2;

    localparam logic [1:0] REG_HIT = 2'd0;
    localparam logic [1:0] REG_SEARCH = 2'd1;
    localparam logic [1:0] REG_DRAIN = 2'd2;

    typedef struct packed {
        logic                 flush;
        logic [ADDR_BITS-1:0] addr;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [17:0] penalty;
        logic        restored;
        logic        written;
        logic [1:0]  way;
        logic [3:0]  level;
        logic [31:0] accesses;
        logic [31:0] misses;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_CLEAR,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

>>> hdl/salc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// salc_front
// input item queue between the stream port and the cache engine
// ---------------------------------------------------------------------------
module salc_front
    import salc_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          in_valid,
    output logic         in_ready,
    input  wire req_t    in_req,
    output logic         q_valid,
    input  wire          q_pop,
    output req_t         q_req
);
    req_t        mem_reg [QDEPTH];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push;

    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop && q_valid)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end
endmodule
`default_nettype wire

>>> hdl/salc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// salc_back
// cache engine: set memory, lru, write buffer, counters and result register
// ---------------------------------------------------------------------------
module salc_back
    import salc_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          q_valid,
    output logic         q_pop,
    input  wire req_t    q_req,
    input  wire [15:0]   hit_pen,
    input  wire [15:0]   search_pen,
    input  wire [15:0]   drain_pen,
    output logic         out_valid,
    input  wire          out_ready,
    output res_t         out_res
);
    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0]     tags;
        logic [WAYS-1:0]                valid;
        logic [WAYS-1:0]                dirty;
        logic [WAYS-1:0][ADDR_BITS-1:0] addrs;
        logic [WAYS-1:0][WAY_W-1:0]     order;
    } row_t;

    row_t                  row_mem [SETS];
    row_t                  row_rd_reg;
    row_t                  row_wr;
    row_t                  row_init;
    logic [SETS-1:0]       row_ok_reg;
    logic                  row_ok_rd_reg;
    row_t                  row_cur;

    logic [BUFFER_DEPTH-1:0][ADDR_BITS-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]      bcnt_reg, bcnt_next;
    logic [31:0]           acc_reg, miss_reg;
    state_t                state_reg, state_next;
    res_t                  res_reg, res_next;
    req_t                  req_reg;

    logic [SET_W-1:0]      set_idx;
    logic [TAG_W-1:0]      tag;
    logic                  found, hit, restored, written;
    logic [WAY_W-1:0]      way, fway, pos;
    logic [17:0]           pen;
    logic                  bmatch;
    logic [BUF_W-1:0]      bidx;

    assign set_idx = (SETS > 1) ? SET_W'(req_reg.addr[ADDR_BITS-1:OFF_W]) : '0;
    assign tag = TAG_W'(req_reg.addr >> (OFF_W + ((SETS > 1) ? SET_W : 0)));

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            row_init.tags[w] = '1;
            row_init.valid[w] = 1'b0;
            row_init.dirty[w] = 1'b0;
            row_init.addrs[w] = '1;
            row_init.order[w] = WAY_W'(w);
        end
        row_cur = row_ok_rd_reg ? row_rd_reg : row_init;
    end

    // classify and update
    always_comb
    begin
        found = 1'b0;
        fway = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row_cur.tags[w] == tag)
            begin
                found = 1'b1;
                fway = WAY_W'(w);
            end
        end
        hit = found && row_cur.valid[fway];
        pen = 18'(hit_pen);
        restored = 1'b0;
        written = 1'b0;
        buf_next = buf_reg;
        bcnt_next = bcnt_reg;
        row_wr = row_cur;
        bmatch = 1'b0;
        bidx = '0;
        way = fway;
        if (!hit)
        begin
            if (bcnt_reg != '0)
            begin
                pen = pen + 18'(search_pen);
                for (int i = BUFFER_DEPTH - 1; i >= 0; i--)
                begin
                    if (CNT_W'(i) < bcnt_reg && buf_reg[i] == req_reg.addr)
                    begin
                        bmatch = 1'b1;
                        bidx = BUF_W'(i);
                    end
                end
                if (bmatch)
                begin
                    restored = 1'b1;
                    for (int i = 0; i < BUFFER_DEPTH - 1; i++)
                    begin
                        if (BUF_W'(i) >= bidx)
                        begin
                            buf_next[i] = buf_reg[i + 1];
                        end
                    end
                    bcnt_next = bcnt_reg - 1'b1;
                end
            end
            if (!found)
            begin
                way = row_cur.order[WAYS-1];
                if (row_cur.valid[way] && row_cur.dirty[way])
                begin
                    written = 1'b1;
                    if (bcnt_next == CNT_W'(BUFFER_DEPTH))
                    begin
                        pen = pen + 18'(drain_pen);
                        for (int i = 0; i < BUFFER_DEPTH - 1; i++)
                        begin
                            buf_next[i] = buf_next[i + 1];
                        end
                        buf_next[BUFFER_DEPTH-1] = row_cur.addrs[way];
                    end
                    else
                    begin
                        buf_next[bcnt_next[BUF_W-1:0]] = row_cur.addrs[way];
                        bcnt_next = bcnt_next + 1'b1;
                    end
                end
                row_wr.tags[way] = tag;
                row_wr.addrs[way] = req_reg.addr;
            end
            row_wr.valid[way] = 1'b1;
            row_wr.dirty[way] = restored;
        end
        pos = WAY_W'(WAYS - 1);
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (row_cur.order[i] == way)
            begin
                pos = WAY_W'(i);
            end
        end
        for (int i = 1; i < WAYS; i++)
        begin
            if (WAY_W'(i) <= pos)
            begin
                row_wr.order[i] = row_cur.order[i-1];
            end
        end
        row_wr.order[0] = way;
        res_next.hit = hit;
        res_next.penalty = pen;
        res_next.restored = restored;
        res_next.written = written;
        res_next.way = 2'(way);
        res_next.level = 4'(bcnt_next);
        res_next.accesses = acc_reg + 32'd1;
        res_next.misses = miss_reg + 32'(!hit);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = q_valid ? (q_req.flush ? ST_CLEAR : ST_READ) : ST_IDLE;
            ST_READ:  state_next = ST_CALC;
            ST_CALC:  state_next = ST_OUT;
            ST_CLEAR: state_next = ST_OUT;
            ST_OUT:   state_next = out_ready ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == ST_IDLE) && q_valid;
        out_valid = (state_reg == ST_OUT);
    end

    assign out_res = res_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            req_reg <= q_req;
        end
        if (state_reg == ST_READ)
        begin
            row_rd_reg <= row_mem[set_idx];
        end
        if (state_reg == ST_CALC)
        begin
            row_mem[set_idx] <= row_wr;
            res_reg <= res_next;
            buf_reg <= buf_next;
        end
        if (state_reg == ST_CLEAR)
        begin
            res_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_ok_reg <= '0;
            row_ok_rd_reg <= 1'b0;
            bcnt_reg <= '0;
            acc_reg <= '0;
            miss_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_READ)
            begin
                row_ok_rd_reg <= row_ok_reg[set_idx];
            end
            if (state_reg == ST_CALC)
            begin
                row_ok_reg[set_idx] <= 1'b1;
                bcnt_reg <= bcnt_next;
                acc_reg <= res_next.accesses;
                miss_reg <= res_next.misses;
            end
            if (state_reg == ST_CLEAR)
            begin
                row_ok_reg <= '0;
                bcnt_reg <= '0;
                acc_reg <= '0;
                miss_reg <= '0;
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/set_assoc_lru_cache_with_write_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// an access passes the idle, read, calc and out states, a flush the idle,
// clear and out states; the engine takes one item at a time, set by the
// single-port set memory (read, then update) and the result register handshake
// a 2-entry input queue lets items be accepted while the engine is busy
// reset clears all cache state at once through per-set valid bits
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_with_write_buffer
// set-associative lru cache timing model with victim write buffer
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_with_write_buffer
    import salc_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire [31:0]   s_tdata,   // address
    input  wire          s_tuser,   // func
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [95:0]  m_tdata,   // hit, penalty_cycles, restored_from_buffer,
                                    // victim_written_back, way_used, buffer_level,
                                    // access_count, miss_count
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [3:0]    paddr,
    input  wire [31:0]   pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [15:0] hit_pen_reg, search_pen_reg, drain_pen_reg;
    req_t        in_req, q_req;
    logic        q_valid, q_pop;
    res_t        res;

    assign pready = 1'b1;
    assign in_req.flush = s_tuser;
    assign in_req.addr = s_tdata[ADDR_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_pen_reg <= 16'd1;
            search_pen_reg <= 16'd1;
            drain_pen_reg <= 16'd10;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                REG_HIT:    hit_pen_reg <= pwdata[15:0];
                REG_SEARCH: search_pen_reg <= pwdata[15:0];
                REG_DRAIN:  drain_pen_reg <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_HIT:    prdata = {16'd0, hit_pen_reg};
            REG_SEARCH: prdata = {16'd0, search_pen_reg};
            REG_DRAIN:  prdata = {16'd0, drain_pen_reg};
            default:    prdata = 32'd0;
        endcase
    end

    salc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    salc_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
        .hit_pen(hit_pen_reg), .search_pen(search_pen_reg), .drain_pen(drain_pen_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {5'd0, res.misses, res.accesses, res.level, res.way,
                      res.written, res.restored, res.penalty, res.hit};
endmodule
`default_nettype wire

>>> hdl/salc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// salc_checker
// port-level checks on the cache result stream
// ---------------------------------------------------------------------------
module salc_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [95:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_hit_pen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tdata[19] && !m_tdata[20])
        else $error("hit with buffer activity");
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[26:23] <= 4'd8)
        else $error("buffer level too high");
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[90:59] <= m_tdata[58:27] || m_tdata[58:27] == 32'd0)
        else $error("misses exceed accesses");
endmodule

bind set_assoc_lru_cache_with_write_buffer salc_checker u_salc_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

>>> tb/sv/tb_set_assoc_lru_cache_with_write_buffer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_set_assoc_lru_cache_with_write_buffer
// drives access and flush items into the cache model with random gaps and
// back-pressure, predicts every result from a behavioral cache model kept
// in the bench, and compares each field of each result in order
// ---------------------------------------------------------------------------
module tb_set_assoc_lru_cache_with_write_buffer;
    import salc_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    set_assoc_lru_cache_with_write_buffer dut (.*);

    typedef struct {
        logic        hit;
        logic [17:0] penalty;
        logic        restored;
        logic        written;
        logic [1:0]  way;
        logic [3:0]  level;
        logic [31:0] accesses;
        logic [31:0] misses;
    } cache_res_t;

    typedef struct {
        logic        flush;
        logic [31:0] addr;
        logic        known;
        logic        k_hit;
        logic [17:0] k_pen;
    } dir_row_t;

    logic [15:0]         hit_pen;
    logic [15:0]         search_pen;
    logic [15:0]         drain_pen;
    logic [TAG_W-1:0]    tags [SETS][WAYS];
    logic                vld [SETS][WAYS];
    logic                dty [SETS][WAYS];
    logic [31:0]         laddr [SETS][WAYS];
    logic [1:0]          order [SETS][WAYS];
    logic [31:0]         wbuf [$];
    logic [31:0]         acc_cnt;
    logic [31:0]         miss_cnt;

    cache_res_t          pending_results [$];
    int                  errors;
    longint              cycles;
    int                  seen;
    logic                long_stall;

    function automatic void clear_cache();
        for (int s = 0; s < SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                tags[s][w] = '1;
                vld[s][w] = 1'b0;
                dty[s][w] = 1'b0;
                laddr[s][w] = '1;
                order[s][w] = w[1:0];
            end
        end
        wbuf.delete();
        acc_cnt = 0;
        miss_cnt = 0;
    endfunction

    function automatic cache_res_t predict_access(logic flush, logic [31:0] a);
        cache_res_t r;
        logic [SET_W-1:0] set;
        logic [TAG_W-1:0] tag;
        int way;
        int p;
        bit found;
        logic [17:0] pen;
        r = '{default: '0};
        if (flush)
        begin
            clear_cache();
            return r;
        end
        set = a[OFF_W +: SET_W];
        tag = a[31 -: TAG_W];
        pen = hit_pen;
        acc_cnt++;
        found = 0;
        way = 0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!found && tags[set][i] == tag)
            begin
                found = 1;
                way = i;
            end
        end
        if (found && vld[set][way])
            r.hit = 1;
        else
        begin
            miss_cnt++;
            if (wbuf.size() != 0)
            begin
                pen += search_pen;
                for (int i = 0; i < wbuf.size(); i++)
                begin
                    if (!r.restored && wbuf[i] == a)
                    begin
                        wbuf.delete(i);
                        r.restored = 1;
                    end
                end
            end
            if (!found)
            begin
                way = order[set][WAYS-1];
                if (vld[set][way] && dty[set][way])
                begin
                    if (wbuf.size() >= BUFFER_DEPTH)
                    begin
                        void'(wbuf.pop_front());
                        pen += drain_pen;
                    end
                    wbuf.push_back(laddr[set][way]);
                    r.written = 1;
                end
                tags[set][way] = tag;
                laddr[set][way] = a;
            end
            vld[set][way] = 1;
            dty[set][way] = r.restored;
        end
        p = WAYS - 1;
        for (int i = WAYS - 1; i >= 0; i--)
            if (order[set][i] == way)
                p = i;
        for (int i = p; i > 0; i--)
            order[set][i] = order[set][i-1];
        order[set][0] = way[1:0];
        r.penalty = pen;
        r.way = way[1:0];
        r.level = 4'(wbuf.size());
        r.accesses = acc_cnt;
        r.misses = miss_cnt;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("tb_set_assoc_lru_cache_with_write_buffer: FAIL");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        cache_res_t e;
        cache_res_t g;
        if (rst_n && m_tvalid && m_tready)
        begin
            g.hit = m_tdata[0];
            g.penalty = m_tdata[18:1];
            g.restored = m_tdata[19];
            g.written = m_tdata[20];
            g.way = m_tdata[22:21];
            g.level = m_tdata[26:23];
            g.accesses = m_tdata[58:27];
            g.misses = m_tdata[90:59];
            seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (g.hit !== e.hit) begin $error("hit exp %0h got %0h", e.hit, g.hit);
                    errors++; end
                if (g.penalty !== e.penalty)
                begin
                    $error("penalty_cycles exp %0h got %0h", e.penalty, g.penalty);
                    errors++;
                end
                if (g.restored !== e.restored)
                begin
                    $error("restored_from_buffer exp %0h got %0h", e.restored, g.restored);
                    errors++;
                end
                if (g.written !== e.written)
                begin
                    $error("victim_written_back exp %0h got %0h", e.written, g.written);
                    errors++;
                end
                if (g.way !== e.way) begin $error("way_used exp %0h got %0h", e.way, g.way);
                    errors++; end
                if (g.level !== e.level)
                begin
                    $error("buffer_level exp %0h got %0h", e.level, g.level);
                    errors++;
                end
                if (g.accesses !== e.accesses)
                begin
                    $error("access_count exp %0h got %0h", e.accesses, g.accesses);
                    errors++;
                end
                if (g.misses !== e.misses)
                begin
                    $error("miss_count exp %0h got %0h", e.misses, g.misses);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall)
                m_tready = 1'b1;
            else if ($urandom_range(0, 3) == 0)
                m_tready = ($urandom_range(0, 19) == 0) ? 1'b0 : ~m_tready;
            else
                m_tready = 1'b1;
            if (!m_tready && $urandom_range(0, 40) == 0)
                repeat ($urandom_range(10, 40)) @(negedge clk);
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [15:0] v);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = {16'($urandom_range(0, 65535)), v};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_HIT:    hit_pen = v;
            REG_SEARCH: search_pen = v;
            default:    drain_pen = v;
        endcase
    endtask

    task automatic send_item(logic flush, logic [31:0] a, logic known, logic k_hit,
                             logic [17:0] k_pen);
        cache_res_t r;
        if ($urandom_range(0, 2) == 0)
            repeat (($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                    : $urandom_range(1, 3)) @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = a;
        s_tuser = flush;
        r = predict_access(flush, a);
        if (known && (r.hit !== k_hit || r.penalty !== k_pen))
        begin
            $error("directed row hit exp %0h got %0h penalty exp %0h got %0h",
                   k_hit, r.hit, k_pen, r.penalty);
            errors++;
        end
        pending_results.push_back(r);
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_addr(int pool);
        logic [31:0] a;
        a = {20'($urandom_range(0, pool)), 12'd0}
            ^ (($urandom_range(0, 1)) ? 32'd0 : 32'hFFFF_F000);
        a[5:0] = 6'($urandom_range(0, 63));
        a[11:6] = 6'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
            a = $urandom;
        return a;
    endfunction

    dir_row_t dir_rows [] = '{
        '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 18'd1},
        '{1'b0, 32'h0000_003F, 1'b1, 1'b1, 18'd1},
        '{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 18'd1},
        '{1'b0, 32'hFFFF_FFC0, 1'b1, 1'b1, 18'd1},
        '{1'b0, 32'h0000_1000, 1'b0, 1'b0, 18'd0},
        '{1'b0, 32'h0000_2000, 1'b0, 1'b0, 18'd0},
        '{1'b0, 32'h0000_3000, 1'b0, 1'b0, 18'd0},
        '{1'b0, 32'h0000_4000, 1'b0, 1'b0, 18'd0},
        '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 18'd0},
        '{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 18'd0},
        '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 18'd1},
        '{1'b0, 32'hAAAA_AAAA, 1'b0, 1'b0, 18'd0},
        '{1'b0, 32'h5555_5555, 1'b0, 1'b0, 18'd0},
        '{1'b1, 32'h0000_0000, 1'b1, 1'b0, 18'd0}
    };

    initial
    begin
        int n;
        int pool;
        logic [31:0] hot [$];
        errors = 0;
        cycles = 0;
        seen = 0;
        long_stall = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hit_pen = 16'd1;
        search_pen = 16'd1;
        drain_pen = 16'd10;
        clear_cache();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (5) @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].flush, dir_rows[i].addr, dir_rows[i].known,
                      dir_rows[i].k_hit, dir_rows[i].k_pen);
        drain_results();

        // phases of register settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin apb_write(REG_HIT, 16'hFFFF); apb_write(REG_SEARCH, 16'hFFFF);
                    apb_write(REG_DRAIN, 16'hFFFF); end
                1: begin apb_write(REG_HIT, 16'd0); apb_write(REG_SEARCH, 16'd0);
                    apb_write(REG_DRAIN, 16'd0); end
                default: begin apb_write(REG_HIT, 16'($urandom_range(0, 65535)));
                    apb_write(REG_SEARCH, 16'($urandom_range(0, 65535)));
                    apb_write(REG_DRAIN, 16'($urandom_range(0, 65535))); end
            endcase
            pool = (ph % 2 == 0) ? 12 : 200;
            for (n = 0; n < 135; n++)
            begin
                logic [31:0] a;
                // a few restore attempts from recently used addresses, mostly set thrash
                if (hot.size() != 0 && $urandom_range(0, 3) == 0)
                    a = hot[$urandom_range(0, hot.size() - 1)];
                else
                begin
                    a = pick_addr(pool);
                    hot.push_back(a);
                    if (hot.size() > 40)
                        void'(hot.pop_front());
                end
                send_item($urandom_range(0, 150) == 0, a, 1'b0, 1'b0, 18'd0);
                if (ph == 3 && n == 60)
                begin
                    long_stall = 1'b1;
                    while (pending_results.size() != 0) @(negedge clk);
                    long_stall = 1'b0;
                end
            end
            drain_results();
        end

        if (errors == 0)
            $display("tb_set_assoc_lru_cache_with_write_buffer: PASS");
        else
            $display("tb_set_assoc_lru_cache_with_write_buffer: FAIL");
        $finish;
    end
endmodule

>>> set_assoc_lru_cache_with_write_buffer.f
hdl/salc_pkg.sv
hdl/salc_front.sv
hdl/salc_back.sv
hdl/set_assoc_lru_cache_with_write_buffer.sv
hdl/salc_checker.sv
tb/sv/tb_set_assoc_lru_cache_with_write_buffer.sv
